@@ rtl/spectral_peak_tracker_top_macros.svh @@
`ifndef SPECTRAL_PEAK_TRACKER_TOP_MACROS_SVH
`define SPECTRAL_PEAK_TRACKER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk and disabled while rst_n is low.
`define SPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk and disabled while rst_n is low.
`define SPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/spt_pkg.sv @@
package spt_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int L2FFT_W    = 4;
  localparam int THR_W      = 12;
  localparam int DELTA_W    = 16;
  localparam int PEAKS_W    = 4;

  localparam logic [CFG_IDX_W-1:0] REG_LOG2_FFT_SIZE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DC_BIN_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DELTA_FRAC       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PEAKS_IN_USE     = 2'd3;

  localparam logic [L2FFT_W-1:0] LOG2_FFT_RST  = 4'd10;
  localparam logic [THR_W-1:0]   DC_THR_RST    = 12'd0;
  localparam logic [DELTA_W-1:0] DELTA_RST     = 16'd3277;
  localparam logic [PEAKS_W-1:0] PEAKS_RST     = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_EMIT
  } spt_state_t;

  typedef struct packed {
    logic capture;
    logic scan;
    logic update;
    logic emit;
    logic clear;
  } spt_cmd_t;

  typedef struct packed {
    logic item_last;
    logic out_free;
  } spt_sts_t;

endpackage

@@ rtl/spt_datapath.sv @@
module spt_datapath #(
  parameter int PEAK_SLOTS   = 8,
  parameter int LOG2_MAX_FFT = 12,
  parameter int MAG_WIDTH    = 24,
  parameter int IDX_W        = 3
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [MAG_WIDTH-1:0]           in_magnitude,
  input  logic                           in_last_bin,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [MAG_WIDTH-1:0]           out_peak_amplitude,
  output logic [LOG2_MAX_FFT-1:0]        out_peak_bin,
  output logic                           out_last_peak,
  input  spt_pkg::spt_cmd_t              cmd,
  input  logic [IDX_W-1:0]               idx,
  output spt_pkg::spt_sts_t              sts,
  output logic [IDX_W-1:0]               last_idx
);
  import spt_pkg::*;

  localparam int B     = LOG2_MAX_FFT;
  localparam int CMP_W = (B > THR_W) ? B : THR_W;
  localparam logic [5:0] MAX_P = 6'(PEAK_SLOTS);

  logic [L2FFT_W-1:0] log2_fft_r;
  logic [THR_W-1:0]   dc_thr_r;
  logic [DELTA_W-1:0] delta_r;
  logic [PEAKS_W-1:0] peaks_r;

  logic [MAG_WIDTH-1:0] cur_mag_r;
  logic [B-1:0]         cur_bin_r;
  logic                 cur_last_r;
  logic [B-1:0]         bin_cnt_r;

  logic [MAG_WIDTH-1:0] ent_mag_r [PEAK_SLOTS];
  logic [B-1:0]         ent_bin_r [PEAK_SLOTS];
  logic [PEAK_SLOTS-1:0] ent_vld_r;

  logic [MAG_WIDTH-1:0] weak_mag_r;
  logic [IDX_W-1:0]     weak_idx_r;
  logic                 nb_fnd_r;
  logic [IDX_W-1:0]     nb_idx_r;
  logic [MAG_WIDTH-1:0] nb_mag_r;

  logic                 out_valid_r;
  logic [MAG_WIDTH-1:0] out_amp_r;
  logic [B-1:0]         out_bin_r;
  logic                 out_last_r;

  logic [5:0]           pu_ext;
  logic [5:0]           n_use;
  logic [MAG_WIDTH-1:0] rd_mag;
  logic [B-1:0]         rd_bin;
  logic [B-1:0]         diff;
  logic [B+15:0]        dist_scaled;
  logic [B+15:0]        reach;
  logic                 hit;
  logic                 first;
  logic                 cand;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [L2FFT_W-1:0]   shift_amt;

  // Number of entries in use, clamped to one through PEAK_SLOTS.
  always_comb begin
    pu_ext = {2'b00, peaks_r};
    if (peaks_r == '0) begin
      n_use = 6'd1;
    end else if (pu_ext > MAX_P) begin
      n_use = MAX_P;
    end else begin
      n_use = pu_ext;
    end
  end
  assign last_idx = IDX_W'(n_use - 6'd1);

  // An entry that is not valid reads as the cleared value.
  assign rd_mag = ent_vld_r[idx] ? ent_mag_r[idx] : '0;
  assign rd_bin = ent_vld_r[idx] ? ent_bin_r[idx] : '0;
  assign first  = (idx == '0);

  // Relative distance test: |p-b| * 2^16 < delta * p.
  assign diff        = (rd_bin > cur_bin_r) ? (rd_bin - cur_bin_r) : (cur_bin_r - rd_bin);
  assign dist_scaled = {diff, 16'h0000};
  assign reach       = delta_r * rd_bin;
  assign hit         = (dist_scaled < reach);

  assign cand = (cur_mag_r > weak_mag_r) && (CMP_W'(cur_bin_r) > CMP_W'(dc_thr_r));

  always_comb begin
    wr_en  = 1'b0;
    wr_idx = weak_idx_r;
    if (cmd.update && cand) begin
      if (nb_fnd_r) begin
        if (cur_mag_r > nb_mag_r) begin
          wr_en  = 1'b1;
          wr_idx = nb_idx_r;
        end
      end else begin
        wr_en = 1'b1;
      end
    end
  end

  assign shift_amt = (log2_fft_r > 4'd1) ? (log2_fft_r - 4'd1) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log2_fft_r <= LOG2_FFT_RST;
      dc_thr_r   <= DC_THR_RST;
      delta_r    <= DELTA_RST;
      peaks_r    <= PEAKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOG2_FFT_SIZE:    log2_fft_r <= cfg_wdata[L2FFT_W-1:0];
        REG_DC_BIN_THRESHOLD: dc_thr_r   <= cfg_wdata[THR_W-1:0];
        REG_DELTA_FRAC:       delta_r    <= cfg_wdata[DELTA_W-1:0];
        REG_PEAKS_IN_USE:     peaks_r    <= cfg_wdata[PEAKS_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_cnt_r <= B'(1);
    end else if (cmd.capture) begin
      bin_cnt_r <= in_last_bin ? B'(1) : (bin_cnt_r + B'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_mag_r  <= in_magnitude;
      cur_bin_r  <= bin_cnt_r;
      cur_last_r <= in_last_bin;
    end
  end

  // Scan pass: first minimum and first neighbor in table order.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      if (first) begin
        weak_mag_r <= rd_mag;
        weak_idx_r <= idx;
        nb_fnd_r   <= hit;
        nb_idx_r   <= idx;
        nb_mag_r   <= rd_mag;
      end else begin
        if (rd_mag < weak_mag_r) begin
          weak_mag_r <= rd_mag;
          weak_idx_r <= idx;
        end
        if (!nb_fnd_r && hit) begin
          nb_fnd_r <= 1'b1;
          nb_idx_r <= idx;
          nb_mag_r <= rd_mag;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
    end else if (cmd.clear) begin
      ent_vld_r <= '0;
    end else if (wr_en) begin
      ent_vld_r[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ent_mag_r[wr_idx] <= cur_mag_r;
      ent_bin_r[wr_idx] <= cur_bin_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_amp_r  <= rd_mag >> shift_amt;
      out_bin_r  <= rd_bin;
      out_last_r <= (idx == last_idx);
    end
  end

  assign sts.item_last = cur_last_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  assign out_valid          = out_valid_r;
  assign out_peak_amplitude = out_amp_r;
  assign out_peak_bin       = out_bin_r;
  assign out_last_peak      = out_last_r;

endmodule

@@ rtl/spt_controller.sv @@
`include "spectral_peak_tracker_top_macros.svh"

module spt_controller #(
  parameter int PEAK_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output spt_pkg::spt_cmd_t cmd,
  output logic [((PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1)-1:0] idx,
  input  spt_pkg::spt_sts_t sts,
  input  logic [((PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1)-1:0] last_idx
);
  import spt_pkg::*;

  localparam int IDX_W = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;

  spt_state_t       state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             at_last;

  assign at_last = (idx_r == last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          idx_nxt     = '0;
          state_nxt   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (at_last) begin
          state_nxt = ST_UPDATE;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        idx_nxt    = '0;
        state_nxt  = sts.item_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (at_last) begin
            cmd.clear = 1'b1;
            idx_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt = idx_r + IDX_W'(1);
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign idx = idx_r;

  `SPT_ASSERT_NXT(a_scan_to_update, (state_r == ST_SCAN) && at_last, state_r == ST_UPDATE, "scan did not end in update")
  `SPT_ASSERT_IMP(a_emit_needs_room, cmd.emit, sts.out_free, "result loaded over a waiting item")
  `SPT_ASSERT_IMP(a_clear_on_final, cmd.clear, cmd.emit && at_last, "table cleared before final result")

endmodule

@@ rtl/spectral_peak_tracker_top.sv @@
// Spectral peak tracker. Bin magnitudes for bins 1 to N/2 of one frame arrive
// as items on the in_ channel, the last one flagged by in_last_bin. The block
// keeps a table of the strongest peaks: a bin is a candidate when it is
// strictly louder than the weakest entry in use (first minimum in table
// order) and its index lies above dc_bin_threshold. If an entry in use lies
// within the relative distance delta_frac (Q0.16) of the candidate, the first
// such entry is replaced, and only when the candidate is louder; otherwise
// the weakest entry is replaced. After the last bin of a frame the entries in
// use are sent on the out_ channel in table order with amplitude
// mag >> (log2_fft_size - 1), bin 0 marking an unused entry and
// out_last_peak marking the final item; the table is then cleared and the
// bin count starts again at one. Each bin is handled in steps: the item is
// taken, then the shared distance multiplier and minimum compare walk the
// table one entry at a time up to the clamped peaks_in_use, and then the
// table is written. After the last bin of a frame the result items follow
// one at a time, each waiting until the output register is free.
// Configuration registers are written through cfg_we, cfg_index and
// cfg_wdata and should be changed only while the block is idle.
module spectral_peak_tracker_top #(
  parameter int PEAK_SLOTS   = 8,
  parameter int LOG2_MAX_FFT = 12,
  parameter int MAG_WIDTH    = 24
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [spt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [MAG_WIDTH-1:0]           in_magnitude,
  input  logic                           in_last_bin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [MAG_WIDTH-1:0]           out_peak_amplitude,
  output logic [LOG2_MAX_FFT-1:0]        out_peak_bin,
  output logic                           out_last_peak
);
  import spt_pkg::*;

  // Width of a table index; a one-entry table still carries a single bit.
  localparam int IDX_W = (PEAK_SLOTS > 1) ? $clog2(PEAK_SLOTS) : 1;

  // Commands from the sequencer and status back from the datapath.
  spt_cmd_t         cmd;
  spt_sts_t         sts;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;

  // The sequencer owns the table walk and the input handshake.
  spt_controller #(
    .PEAK_SLOTS (PEAK_SLOTS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .idx      (idx),
    .sts      (sts),
    .last_idx (last_idx)
  );

  // The datapath holds the registers, the peak table and the output register.
  spt_datapath #(
    .PEAK_SLOTS   (PEAK_SLOTS),
    .LOG2_MAX_FFT (LOG2_MAX_FFT),
    .MAG_WIDTH    (MAG_WIDTH),
    .IDX_W        (IDX_W)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_magnitude       (in_magnitude),
    .in_last_bin        (in_last_bin),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_peak_amplitude (out_peak_amplitude),
    .out_peak_bin       (out_peak_bin),
    .out_last_peak      (out_last_peak),
    .cmd                (cmd),
    .idx                (idx),
    .sts                (sts),
    .last_idx           (last_idx)
  );

endmodule

@@ verif/spectral_peak_tracker_top_tb.sv @@
// One expected result item: a single entry of the peak table as it leaves the block.
typedef struct packed {
  logic [23:0] amp;
  logic [11:0] bin;
  logic        is_last;
} peak_item_t;

// Keeps its own copy of the peak table and the register settings. It works out
// the peaks each frame should produce and checks the items that come out.
class peak_table_checker;
  logic [3:0]  log2_size;
  logic [11:0] dc_thr;
  logic [15:0] delta;
  logic [3:0]  peaks_cfg;
  logic [23:0] entry_mag [8];
  logic [11:0] entry_bin [8];
  logic [11:0] bin_count;
  peak_item_t  expected_peaks [$];
  int unsigned failures;

  function new();
    log2_size = spt_pkg::LOG2_FFT_RST;
    dc_thr    = spt_pkg::DC_THR_RST;
    delta     = spt_pkg::DELTA_RST;
    peaks_cfg = spt_pkg::PEAKS_RST;
    failures  = 0;
    clear_table();
  endfunction

  function void clear_table();
    for (int i = 0; i < 8; i++) begin
      entry_mag[i] = '0;
      entry_bin[i] = '0;
    end
    bin_count = 12'd1;
  endfunction

  function int unsigned used_entries();
    if (peaks_cfg == 0) return 1;
    if (peaks_cfg > 8) return 8;
    return peaks_cfg;
  endfunction

  function void set_reg(logic [1:0] idx, logic [15:0] val);
    case (idx)
      spt_pkg::REG_LOG2_FFT_SIZE:    log2_size = val[3:0];
      spt_pkg::REG_DC_BIN_THRESHOLD: dc_thr    = val[11:0];
      spt_pkg::REG_DELTA_FRAC:       delta     = val;
      spt_pkg::REG_PEAKS_IN_USE:     peaks_cfg = val[3:0];
      default: ;
    endcase
  endfunction

  // An entry with bin 0 can never be near anything, since its allowed distance is 0.
  function bit near_entry(logic [11:0] p, logic [11:0] b);
    logic [63:0] diff;
    diff = (p > b) ? 64'(p - b) : 64'(b - p);
    return (diff << 16) < (64'(delta) * 64'(p));
  endfunction

  function void place_bin(logic [23:0] mag, logic [11:0] b);
    int unsigned n;
    int unsigned weakest;
    n = used_entries();
    weakest = 0;
    for (int unsigned i = 1; i < n; i++) begin
      if (entry_mag[i] < entry_mag[weakest]) weakest = i;
    end
    if (!(mag > entry_mag[weakest])) return;
    if (!(b > dc_thr)) return;
    for (int unsigned i = 0; i < n; i++) begin
      if (near_entry(entry_bin[i], b)) begin
        if (mag > entry_mag[i]) begin
          entry_mag[i] = mag;
          entry_bin[i] = b;
        end
        return;
      end
    end
    entry_mag[weakest] = mag;
    entry_bin[weakest] = b;
  endfunction

  function void note_bin(logic [23:0] mag, logic frame_end);
    int unsigned n;
    int unsigned sh;
    peak_item_t pk;
    place_bin(mag, bin_count);
    bin_count = bin_count + 12'd1;
    if (!frame_end) return;
    n = used_entries();
    sh = (log2_size > 1) ? log2_size - 1 : 0;
    for (int unsigned i = 0; i < n; i++) begin
      pk.amp = entry_mag[i] >> sh;
      pk.bin = entry_bin[i];
      pk.is_last = (i + 1 == n);
      expected_peaks.push_back(pk);
    end
    clear_table();
  endfunction

  function void check_peak(logic [23:0] amp, logic [11:0] b, logic is_last);
    peak_item_t want;
    if (expected_peaks.size() == 0) begin
      $display("%0t: unexpected peak item, amplitude %0h bin %0d last %0b",
               $time, amp, b, is_last);
      failures++;
      return;
    end
    want = expected_peaks.pop_front();
    if (amp !== want.amp) begin
      $display("%0t: peak_amplitude mismatch, expected %0h actual %0h", $time, want.amp, amp);
      failures++;
    end
    if (b !== want.bin) begin
      $display("%0t: peak_bin mismatch, expected %0d actual %0d", $time, want.bin, b);
      failures++;
    end
    if (is_last !== want.is_last) begin
      $display("%0t: last_peak mismatch, expected %0b actual %0b", $time, want.is_last,
               is_last);
      failures++;
    end
  endfunction

  function int unsigned pending();
    return expected_peaks.size();
  endfunction
endclass

module spectral_peak_tracker_top_tb;
  import spt_pkg::*;

  // Each bin walks at most the eight table entries, and a frame end sends one item
  // per entry. This many quiet cycles after the last expected item means the block is idle.
  localparam int unsigned SETTLE_CYCLES = 32;
  localparam int unsigned RANDOM_BINS   = 300;
  localparam int unsigned TAIL_BINS     = 250;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [23:0] in_magnitude = '0;
  logic        in_last_bin = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_peak_amplitude;
  logic [11:0] out_peak_bin;
  logic        out_last_peak;

  peak_table_checker tracker_model = new();

  // Idling controls. The sender and the receiver each pause in bursts while their
  // flag is set; the main sequence turns them off for some phases and for the tail.
  bit          sender_idles = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned stall_left = 0;
  int unsigned random_bins = 0;

  always #5 clk = ~clk;

  spectral_peak_tracker_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_magnitude       (in_magnitude),
    .in_last_bin        (in_last_bin),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_peak_amplitude (out_peak_amplitude),
    .out_peak_bin       (out_peak_bin),
    .out_last_peak      (out_last_peak)
  );

  // Receiver side. A stall burst holds out_ready low while its countdown runs. Values are
  // sampled right at the edge, so they are the ones the block saw for that edge.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (receiver_stalls && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result item accepted by the receiver is checked against the oldest
  // expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      tracker_model.check_peak(out_peak_amplitude, out_peak_bin, out_last_peak);
    end
  end

  // Sends one bin item and waits for it to be accepted. Within this task the valid
  // line is lowered only at the start of a gap, so it never gets two updates in one step.
  task automatic send_bin(logic [23:0] mag, logic frame_end);
    int unsigned gap;
    gap = 0;
    if (sender_idles && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_magnitude <= mag;
    in_last_bin <= frame_end;
    do @(posedge clk); while (!in_ready);
    tracker_model.note_bin(mag, frame_end);
  endtask

  // Stops sending, waits for every expected item and then gives the block time to
  // finish any bin that produces no result.
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker_model.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while the block is idle, so the model may take the new value at once.
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tracker_model.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic configure(logic [15:0] l2, logic [15:0] thr, logic [15:0] dlt,
                           logic [15:0] pk);
    settle();
    write_reg(REG_LOG2_FFT_SIZE, l2);
    write_reg(REG_DC_BIN_THRESHOLD, thr);
    write_reg(REG_DELTA_FRAC, dlt);
    write_reg(REG_PEAKS_IN_USE, pk);
  endtask

  // Spectra are mostly a low noise floor with scattered strong peaks, so that the
  // table fills, entries get displaced and near neighbors compete.
  function automatic logic [23:0] pick_magnitude();
    case ($urandom_range(0, 5))
      0:       return 24'($urandom());
      1:       return 24'hFFFFF0 | 24'($urandom_range(0, 15));
      2:       return 24'($urandom_range(0, 4095));
      default: return 24'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_log2();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd2;
      3:       return 16'd12;
      4:       return 16'd15;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_threshold();
    case ($urandom_range(0, 7))
      0:       return 16'd4095;
      1:       return 16'($urandom());
      2:       return 16'd0;
      default: return 16'($urandom_range(0, 12));
    endcase
  endfunction

  function automatic logic [15:0] pick_delta();
    case ($urandom_range(0, 4))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd3277;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] pick_peaks();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd8;
      3:       return 16'($urandom_range(9, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  initial begin
    int unsigned frames;
    int unsigned len;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. The first frame runs on the reset settings: a silent bin that
    // cannot enter the table, the loudest magnitude, and a frame too short to fill
    // all eight entries, so unused entries come out as zero amplitude and bin 0.
    send_bin(24'd0, 1'b0);
    send_bin(24'hFFFFFF, 1'b0);
    send_bin(24'd1, 1'b0);
    send_bin(24'd800, 1'b0);
    send_bin(24'd801, 1'b0);
    send_bin(24'd5, 1'b0);
    send_bin(24'd7, 1'b1);

    // Zero transform size means no shift; an entry count of zero acts as one. The
    // threshold hides the first three bins, and the widest distance makes bin 5 a
    // neighbor of bin 4, so it replaces it.
    configure(16'd0, 16'd3, 16'hFFFF, 16'd0);
    send_bin(24'd10, 1'b0);
    send_bin(24'd20, 1'b0);
    send_bin(24'd30, 1'b0);
    send_bin(24'd40, 1'b0);
    send_bin(24'd50, 1'b1);

    // A transform size of one also means no shift, and counts above eight act as
    // eight. The upper bits of the threshold write are dropped, leaving 0. Equal
    // magnitudes test the strict comparisons.
    configure(16'd1, 16'hF000, 16'd0, 16'd15);
    send_bin(24'd100, 1'b0);
    send_bin(24'd100, 1'b0);
    send_bin(24'd100, 1'b1);

    // Largest shift, and a threshold that blocks every bin.
    configure(16'd15, 16'd4095, 16'd3277, 16'd8);
    send_bin(24'hFFFFFF, 1'b1);

    // Settings changed in the middle of a frame: the entry count grows from two to
    // four, and the amplitude scaling changes before the frame is emitted.
    configure(16'd12, 16'd0, 16'd3277, 16'd2);
    send_bin(24'd50, 1'b0);
    send_bin(24'd60, 1'b0);
    send_bin(24'd70, 1'b0);
    settle();
    write_reg(REG_PEAKS_IN_USE, 16'd4);
    write_reg(REG_LOG2_FFT_SIZE, 16'd2);
    send_bin(24'd80, 1'b0);
    send_bin(24'd90, 1'b1);

    // Random part. Each phase picks new settings and idling, then sends a few frames.
    // Most frames are short so that many of them end; a few are long enough for
    // the relative distance test to matter at usual delta values.
    while (random_bins < RANDOM_BINS) begin
      configure(pick_log2(), pick_threshold(), pick_delta(), pick_peaks());
      if (random_bins >= TAIL_BINS) begin
        sender_idles = 1'b0;
        receiver_stalls = 1'b0;
      end else begin
        sender_idles = ($urandom_range(0, 3) != 0);
        receiver_stalls = ($urandom_range(0, 3) != 0);
      end
      frames = $urandom_range(1, 4);
      for (int unsigned f = 0; f < frames; f++) begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 16);
        for (int unsigned i = 0; i < len; i++) begin
          // Now and then the settings change while a frame is open.
          if (i != 0 && $urandom_range(0, 40) == 0) begin
            settle();
            if ($urandom_range(0, 1) == 0) write_reg(REG_PEAKS_IN_USE, pick_peaks());
            else write_reg(REG_DC_BIN_THRESHOLD, pick_threshold());
          end
          send_bin(pick_magnitude(), i == len - 1);
        end
        random_bins += len;
        // Sometimes hold back until the receiver has taken every peak of the frame.
        if ($urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          while (tracker_model.pending() != 0) @(posedge clk);
        end
      end
    end

    settle();
    if (tracker_model.failures == 0) begin
      $display("spectral_peak_tracker_top_tb: PASS");
    end else begin
      $display("spectral_peak_tracker_top_tb: FAIL");
    end
    $finish;
  end

  // A correct run needs well under a tenth of this time, even with every stall at
  // its longest.
  initial begin
    #5000000;
    $display("spectral_peak_tracker_top_tb: FAIL");
    $finish;
  end

endmodule
